// ===== rtl/core/vfc_pkg.sv =====
// shared constants, types and address helpers for the voxel face culler
`default_nettype none

package vfc_pkg;

	localparam int CHUNK_EDGE = 16;
	localparam int CW         = $clog2(CHUNK_EDGE);
	localparam int VOXELS     = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
	localparam int VAW        = $clog2(VOXELS);
	localparam int NUM_SIDES  = 6;
	localparam int BND_DEPTH  = NUM_SIDES * CHUNK_EDGE * CHUNK_EDGE;
	localparam int BAW        = $clog2(BND_DEPTH);

	localparam int OP_W      = 2;
	localparam int POS_W     = 4;
	localparam int ID_W      = 6;
	localparam int SIDE_W    = 3;
	localparam int WORLD_W   = 25;
	localparam int CPOS_W    = 21;
	localparam int TMASK_W   = 63;
	localparam int PRESENT_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 63;

	localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(NUM_SIDES - 1);

	typedef enum logic [OP_W-1:0] {
		OP_WR_VOXEL = 2'd0,
		OP_WR_BOUND = 2'd1,
		OP_EXAMINE  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TMASK   = 3'd0,
		REG_CHUNK_X = 3'd1,
		REG_CHUNK_Y = 3'd2,
		REG_CHUNK_Z = 3'd3,
		REG_PRESENT = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SELF,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic           at_edge;
		logic [VAW-1:0] vaddr;
		logic [BAW-1:0] baddr;
	} side_geom_t;

	function automatic logic [VAW-1:0] vox_addr(input logic [CW-1:0] x,
		input logic [CW-1:0] y, input logic [CW-1:0] z);
		return VAW'((int'(x) * CHUNK_EDGE + int'(y)) * CHUNK_EDGE + int'(z));
	endfunction

	function automatic logic [BAW-1:0] bnd_addr(input logic [SIDE_W-1:0] side,
		input logic [CW-1:0] a, input logic [CW-1:0] b);
		return BAW'((int'(side) * CHUNK_EDGE + int'(a)) * CHUNK_EDGE + int'(b));
	endfunction

	// neighbour address inside the chunk, boundary address and edge flag for one side
	function automatic side_geom_t side_geom(input logic [SIDE_W-1:0] side,
		input logic [CW-1:0] x, input logic [CW-1:0] y, input logic [CW-1:0] z);
		logic          plus;
		logic [CW-1:0] pa;
		logic [CW-1:0] a;
		logic [CW-1:0] b;
		logic [CW-1:0] qx;
		logic [CW-1:0] qy;
		logic [CW-1:0] qz;
		side_geom_t    g;
		plus = !side[0];
		qx = x;
		qy = y;
		qz = z;
		case (side[2:1])
			2'd0: begin
				pa = x; a = y; b = z;
				qx = plus ? x + CW'(1) : x - CW'(1);
			end
			2'd1: begin
				pa = y; a = x; b = z;
				qy = plus ? y + CW'(1) : y - CW'(1);
			end
			default: begin
				pa = z; a = x; b = y;
				qz = plus ? z + CW'(1) : z - CW'(1);
			end
		endcase
		g.at_edge = plus ? (pa == CW'(CHUNK_EDGE - 1)) : (pa == '0);
		g.vaddr   = vox_addr(qx, qy, qz);
		g.baddr   = bnd_addr(side, a, b);
		return g;
	endfunction

	function automatic logic signed [WORLD_W-1:0] world_coord(
		input logic signed [CPOS_W-1:0] c, input logic [CW-1:0] p);
		return WORLD_W'(int'(c) * CHUNK_EDGE + int'(p));
	endfunction

	// id 0 is never transparent
	function automatic logic is_transparent(input logic [TMASK_W-1:0] tmask,
		input logic [ID_W-1:0] id);
		logic [TMASK_W:0] v;
		v = {tmask, 1'b0};
		return v[id];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/voxel_face_culler_unit.sv =====
// voxel face culler: chunk and boundary stores, examine sequencer and face output register
//
// Keeps a 16x16x16 chunk of 6-bit voxel ids plus the facing boundary layer of each of the six
// neighbour chunks. After reset the chunk store is swept to empty, one entry per cycle, and
// in_ready stays low during the sweep while configuration writes are taken. Voxel and boundary
// writes go into their store in the cycle of their transfer. An examine reads the voxel itself
// and, if it is not empty, one neighbour per side from the single-port chunk and boundary stores,
// one read per cycle while no face waits for out_ready; in_ready stays low until it ends, and a
// final state sends the held-back face when the -z face and an earlier face are both visible
// (one visible face is held back for last_face). Faces come out in the order +x,-x,+y,-y,+z,-z.
`default_nettype none

module voxel_face_culler_unit (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        in_valid,
	output logic                                       in_ready,
	input  wire  [vfc_pkg::OP_W-1:0]                   opcode,
	input  wire  [vfc_pkg::POS_W-1:0]                  pos_x,
	input  wire  [vfc_pkg::POS_W-1:0]                  pos_y,
	input  wire  [vfc_pkg::POS_W-1:0]                  pos_z,
	input  wire  [vfc_pkg::ID_W-1:0]                   voxel_id,
	input  wire  [vfc_pkg::SIDE_W-1:0]                 face_side,
	output logic                                       out_valid,
	input  wire                                        out_ready,
	output logic signed [vfc_pkg::WORLD_W-1:0]         world_x,
	output logic signed [vfc_pkg::WORLD_W-1:0]         world_y,
	output logic signed [vfc_pkg::WORLD_W-1:0]         world_z,
	output logic [vfc_pkg::SIDE_W-1:0]                 face_dir,
	output logic [vfc_pkg::ID_W-1:0]                   block_id,
	output logic                                       to_transparent,
	output logic                                       last_face,
	input  wire                                        cfg_wr_en,
	input  wire  [vfc_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  wire  [vfc_pkg::CFG_W-1:0]                  cfg_data
);

	vfc_pkg::state_t state_q, state_d;

	logic [vfc_pkg::VAW-1:0]    clr_q;
	logic [vfc_pkg::CW-1:0]     px_q, py_q, pz_q;
	logic [vfc_pkg::ID_W-1:0]   self_q;
	logic                       self_tr_q;
	logic [vfc_pkg::SIDE_W-1:0] side_q;
	logic                       pend_valid_q;
	logic [vfc_pkg::SIDE_W-1:0] pend_dir_q;

	logic [vfc_pkg::TMASK_W-1:0]     tmask_q;
	logic signed [vfc_pkg::CPOS_W-1:0] chunk_x_q, chunk_y_q, chunk_z_q;
	logic [vfc_pkg::PRESENT_W-1:0]   present_q;

	logic                               out_valid_q;
	logic signed [vfc_pkg::WORLD_W-1:0] world_x_q, world_y_q, world_z_q;
	logic [vfc_pkg::SIDE_W-1:0]         face_dir_q;
	logic [vfc_pkg::ID_W-1:0]           block_id_q;
	logic                               to_tr_q;
	logic                               last_face_q;

	logic [vfc_pkg::ID_W-1:0] vox_mem [vfc_pkg::VOXELS];
	logic [vfc_pkg::ID_W-1:0] bnd_mem [vfc_pkg::BND_DEPTH];
	logic [vfc_pkg::ID_W-1:0] vox_rdata_q;
	logic [vfc_pkg::ID_W-1:0] bnd_rdata_q;

	logic                       in_fire;
	logic                       in_range;
	logic [vfc_pkg::CW-1:0]     in_x, in_y, in_z;
	logic                       last_side;
	logic [vfc_pkg::SIDE_W-1:0] nxt_side;
	vfc_pkg::side_geom_t        geom_cur, geom_nxt, geom_in;
	logic [vfc_pkg::ID_W-1:0]   nb_id;
	logic                       vis;
	logic                       out_free;

	logic                       vox_we, vox_re, bnd_we, bnd_re;
	logic [vfc_pkg::VAW-1:0]    vox_addr_c;
	logic [vfc_pkg::BAW-1:0]    bnd_addr_c;
	logic [vfc_pkg::ID_W-1:0]   vox_wdata;
	logic                       emit_valid, emit_last, advance, pend_load;
	logic [vfc_pkg::SIDE_W-1:0] emit_dir;

	assign in_fire  = in_valid && in_ready;
	assign in_range = (int'(pos_x) < vfc_pkg::CHUNK_EDGE) && (int'(pos_y) < vfc_pkg::CHUNK_EDGE)
		&& (int'(pos_z) < vfc_pkg::CHUNK_EDGE);
	assign in_x = vfc_pkg::CW'(pos_x);
	assign in_y = vfc_pkg::CW'(pos_y);
	assign in_z = vfc_pkg::CW'(pos_z);

	assign last_side = (side_q == vfc_pkg::SIDE_LAST);
	assign nxt_side  = (state_q == vfc_pkg::ST_SELF) ? '0 : side_q + vfc_pkg::SIDE_W'(1);
	assign geom_cur  = vfc_pkg::side_geom(side_q, px_q, py_q, pz_q);
	assign geom_nxt  = vfc_pkg::side_geom(nxt_side, px_q, py_q, pz_q);
	assign geom_in   = vfc_pkg::side_geom(face_side, in_x, in_y, in_z);
	assign out_free  = !out_valid_q || out_ready;

	// visibility of the side whose neighbour id sits in the read registers
	always_comb begin
		nb_id = geom_cur.at_edge ? bnd_rdata_q : vox_rdata_q;
		if (geom_cur.at_edge && !present_q[side_q]) begin
			vis = 1'b1;
		end else begin
			vis = (nb_id == '0) || (!self_tr_q && vfc_pkg::is_transparent(tmask_q, nb_id));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfc_pkg::ST_CLEAR: begin
				if (clr_q == vfc_pkg::VAW'(vfc_pkg::VOXELS - 1)) state_d = vfc_pkg::ST_IDLE;
			end
			vfc_pkg::ST_IDLE: begin
				if (in_fire && in_range && opcode == vfc_pkg::OP_EXAMINE)
					state_d = vfc_pkg::ST_SELF;
			end
			vfc_pkg::ST_SELF: begin
				state_d = (vox_rdata_q == '0) ? vfc_pkg::ST_IDLE : vfc_pkg::ST_SCAN;
			end
			vfc_pkg::ST_SCAN: begin
				if (advance && last_side)
					state_d = (vis && pend_valid_q) ? vfc_pkg::ST_FLUSH : vfc_pkg::ST_IDLE;
			end
			vfc_pkg::ST_FLUSH: begin
				if (advance) state_d = vfc_pkg::ST_IDLE;
			end
			default: state_d = vfc_pkg::ST_IDLE;
		endcase
	end

	// store access and face emission
	always_comb begin
		in_ready   = 1'b0;
		vox_we     = 1'b0;
		vox_re     = 1'b0;
		bnd_we     = 1'b0;
		bnd_re     = 1'b0;
		vox_addr_c = geom_nxt.vaddr;
		bnd_addr_c = geom_nxt.baddr;
		vox_wdata  = voxel_id;
		emit_valid = 1'b0;
		emit_dir   = pend_dir_q;
		emit_last  = 1'b0;
		advance    = 1'b1;
		pend_load  = 1'b0;
		unique case (state_q)
			vfc_pkg::ST_CLEAR: begin
				vox_we     = 1'b1;
				vox_addr_c = clr_q;
				vox_wdata  = '0;
			end
			vfc_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				vox_addr_c = vfc_pkg::vox_addr(in_x, in_y, in_z);
				bnd_addr_c = geom_in.baddr;
				if (in_fire && in_range) begin
					case (opcode)
						vfc_pkg::OP_WR_VOXEL: vox_we = 1'b1;
						vfc_pkg::OP_WR_BOUND: bnd_we = (int'(face_side) < vfc_pkg::NUM_SIDES);
						vfc_pkg::OP_EXAMINE:  vox_re = 1'b1;
						default: ;
					endcase
				end
			end
			vfc_pkg::ST_SELF: begin
				vox_re = 1'b1;
				bnd_re = 1'b1;
			end
			vfc_pkg::ST_SCAN: begin
				// one visible face is held back until the next one or the end is known
				if (pend_valid_q && (vis || last_side)) begin
					emit_valid = 1'b1;
					emit_last  = last_side && !vis;
				end else if (!pend_valid_q && vis && last_side) begin
					emit_valid = 1'b1;
					emit_dir   = side_q;
					emit_last  = 1'b1;
				end
				pend_load = vis && !(last_side && !pend_valid_q);
				advance   = !emit_valid || out_free;
				vox_re    = advance && !last_side;
				bnd_re    = advance && !last_side;
			end
			vfc_pkg::ST_FLUSH: begin
				emit_valid = 1'b1;
				emit_last  = 1'b1;
				advance    = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vfc_pkg::ST_CLEAR;
			clr_q        <= '0;
			side_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vfc_pkg::ST_CLEAR) clr_q <= clr_q + vfc_pkg::VAW'(1);
			if (state_q == vfc_pkg::ST_SELF) begin
				side_q       <= '0;
				pend_valid_q <= 1'b0;
			end else if (state_q == vfc_pkg::ST_SCAN && advance) begin
				side_q       <= side_q + vfc_pkg::SIDE_W'(1);
				pend_valid_q <= pend_load || (pend_valid_q && !emit_valid);
			end else if (state_q == vfc_pkg::ST_FLUSH && advance) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_q <= in_x;
			py_q <= in_y;
			pz_q <= in_z;
		end
		if (state_q == vfc_pkg::ST_SELF) begin
			self_q    <= vox_rdata_q;
			self_tr_q <= vfc_pkg::is_transparent(tmask_q, vox_rdata_q);
		end
		if (state_q == vfc_pkg::ST_SCAN && advance && pend_load) pend_dir_q <= side_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmask_q   <= '0;
			chunk_x_q <= '0;
			chunk_y_q <= '0;
			chunk_z_q <= '0;
			present_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				vfc_pkg::REG_TMASK:   tmask_q   <= cfg_data[vfc_pkg::TMASK_W-1:0];
				vfc_pkg::REG_CHUNK_X: chunk_x_q <= cfg_data[vfc_pkg::CPOS_W-1:0];
				vfc_pkg::REG_CHUNK_Y: chunk_y_q <= cfg_data[vfc_pkg::CPOS_W-1:0];
				vfc_pkg::REG_CHUNK_Z: chunk_z_q <= cfg_data[vfc_pkg::CPOS_W-1:0];
				vfc_pkg::REG_PRESENT: present_q <= cfg_data[vfc_pkg::PRESENT_W-1:0];
				default: ;
			endcase
		end
	end

	// chunk store, single port
	always_ff @(posedge clk) begin
		if (vox_we) begin
			vox_mem[vox_addr_c] <= vox_wdata;
		end else if (vox_re) begin
			vox_rdata_q <= vox_mem[vox_addr_c];
		end
	end

	// boundary store, single port
	always_ff @(posedge clk) begin
		if (bnd_we) begin
			bnd_mem[bnd_addr_c] <= voxel_id;
		end else if (bnd_re) begin
			bnd_rdata_q <= bnd_mem[bnd_addr_c];
		end
	end

	// face output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && out_free) begin
			world_x_q   <= vfc_pkg::world_coord(chunk_x_q, px_q);
			world_y_q   <= vfc_pkg::world_coord(chunk_y_q, py_q);
			world_z_q   <= vfc_pkg::world_coord(chunk_z_q, pz_q);
			face_dir_q  <= emit_dir;
			block_id_q  <= self_q;
			to_tr_q     <= self_tr_q;
			last_face_q <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign world_x        = world_x_q;
	assign world_y        = world_y_q;
	assign world_z        = world_z_q;
	assign face_dir       = face_dir_q;
	assign block_id       = block_id_q;
	assign to_transparent = to_tr_q;
	assign last_face      = last_face_q;

	// checks
	a_pend_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfc_pkg::ST_IDLE |-> !pend_valid_q)
		else $error("held-back face left over outside an examine");

	a_face_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> block_id != '0)
		else $error("face record for an empty voxel");

	a_examine_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_range && opcode == vfc_pkg::OP_EXAMINE
		|=> state_q == vfc_pkg::ST_SELF)
		else $error("examine transfer did not start the voxel read");

	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfc_pkg::ST_FLUSH |-> pend_valid_q)
		else $error("final face state without a held-back face");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfc_pkg::ST_CLEAR && clr_q == vfc_pkg::VAW'(vfc_pkg::VOXELS - 1)
		|=> state_q == vfc_pkg::ST_IDLE)
		else $error("clearing sweep did not end on the last entry");

	a_scan_side: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfc_pkg::ST_SCAN && emit_valid && !out_free |=> $stable(side_q))
		else $error("side advanced while a face was stalled");

endmodule

`default_nettype wire

// ===== sim/voxel_face_culler_unit_tb.sv =====
// self-checking testbench for voxel_face_culler_unit: directed table, then random traffic
`timescale 1ns / 100ps

module voxel_face_culler_unit_tb;
	import vfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PHASE_ITEMS    = 80;
	localparam int RANDOM_PHASES  = 6;
	localparam int PLAN_ROWS      = 23;

	localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
	localparam logic [SIDE_W-1:0] SIDE_PX    = 3'd0;
	localparam logic [SIDE_W-1:0] SIDE_NX    = 3'd1;
	localparam logic [SIDE_W-1:0] SIDE_PY    = 3'd2;
	localparam logic [SIDE_W-1:0] SIDE_NY    = 3'd3;
	localparam logic [SIDE_W-1:0] SIDE_PZ    = 3'd4;
	localparam logic [SIDE_W-1:0] SIDE_NZ    = 3'd5;
	localparam logic [SIDE_W-1:0] SIDE_BAD_A = 3'd6;
	localparam logic [SIDE_W-1:0] SIDE_BAD_B = 3'd7;
	localparam logic [POS_W-1:0]  POS_MAX    = POS_W'(CHUNK_EDGE - 1);
	localparam logic [CPOS_W-1:0] CPOS_MAX   = {1'b0, {(CPOS_W-1){1'b1}}};
	localparam logic [CPOS_W-1:0] CPOS_MIN   = {1'b1, {(CPOS_W-1){1'b0}}};

	typedef struct packed {
		logic signed [WORLD_W-1:0] wx;
		logic signed [WORLD_W-1:0] wy;
		logic signed [WORLD_W-1:0] wz;
		logic [SIDE_W-1:0]         dir;
		logic [ID_W-1:0]           id;
		logic                      tr;
		logic                      last;
	} face_rec_t;

	// typed rows carry the visible faces, the id and the mesh flag of an examine
	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [POS_W-1:0]     x;
		logic [POS_W-1:0]     y;
		logic [POS_W-1:0]     z;
		logic [ID_W-1:0]      id;
		logic [SIDE_W-1:0]    side;
		logic                 typed;
		logic [NUM_SIDES-1:0] faces;
		logic                 tr;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [OP_W-1:0]            opcode = '0;
	logic [POS_W-1:0]           pos_x = '0;
	logic [POS_W-1:0]           pos_y = '0;
	logic [POS_W-1:0]           pos_z = '0;
	logic [ID_W-1:0]            voxel_id = '0;
	logic [SIDE_W-1:0]          face_side = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [WORLD_W-1:0]  world_x;
	logic signed [WORLD_W-1:0]  world_y;
	logic signed [WORLD_W-1:0]  world_z;
	logic [SIDE_W-1:0]          face_dir;
	logic [ID_W-1:0]            block_id;
	logic                       to_transparent;
	logic                       last_face;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	logic [ID_W-1:0]      chunk_image [VOXELS];
	logic [ID_W-1:0]      border_image [BND_DEPTH];
	bit                   border_known [BND_DEPTH];
	logic [TMASK_W-1:0]   see_through;
	logic [CPOS_W-1:0]    origin_x;
	logic [CPOS_W-1:0]    origin_y;
	logic [CPOS_W-1:0]    origin_z;
	logic [NUM_SIDES-1:0] neighbour_on;
	face_rec_t            faces_due [$];
	int                   errors = 0;
	int                   sender_idle_pct = 0;
	int                   receiver_idle_pct = 0;
	int                   quiet_cycles = 0;

	stim_row_t plan [PLAN_ROWS] = '{
		'{OP_EXAMINE,  4'd0,  4'd0,  4'd0,  6'd0,  SIDE_PX,    1'b1, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd15, 4'd15, 4'd15, 6'd63, SIDE_BAD_B, 1'b1, 6'b000000, 1'b0},
		'{OP_WR_BOUND, 4'd9,  4'd0,  4'd0,  6'd0,  SIDE_NX,    1'b0, 6'b000000, 1'b0},
		'{OP_WR_BOUND, 4'd0,  4'd7,  4'd0,  6'd2,  SIDE_NY,    1'b0, 6'b000000, 1'b0},
		'{OP_WR_BOUND, 4'd0,  4'd0,  4'd3,  6'd1,  SIDE_NZ,    1'b0, 6'b000000, 1'b0},
		'{OP_WR_BOUND, 4'd0,  4'd0,  4'd0,  6'd5,  SIDE_BAD_A, 1'b0, 6'b000000, 1'b0},
		'{OP_WR_BOUND, 4'd15, 4'd15, 4'd15, 6'd63, SIDE_BAD_B, 1'b0, 6'b000000, 1'b0},
		'{OP_WR_VOXEL, 4'd0,  4'd0,  4'd0,  6'd63, SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd0,  4'd0,  4'd0,  6'd63, SIDE_PX,    1'b1, 6'b010111, 1'b1},
		'{OP_WR_VOXEL, 4'd0,  4'd0,  4'd0,  6'd1,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd0,  4'd0,  4'd0,  6'd0,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_WR_VOXEL, 4'd15, 4'd15, 4'd15, 6'd2,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd15, 4'd15, 4'd15, 6'd2,  SIDE_PX,    1'b1, 6'b111111, 1'b1},
		'{OP_WR_VOXEL, 4'd14, 4'd15, 4'd15, 6'd1,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd15, 4'd15, 4'd15, 6'd0,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd14, 4'd15, 4'd15, 6'd0,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_SPARE,    4'd3,  4'd3,  4'd3,  6'd9,  SIDE_PY,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd3,  4'd3,  4'd3,  6'd0,  SIDE_PX,    1'b1, 6'b000000, 1'b0},
		'{OP_WR_VOXEL, 4'd15, 4'd5,  4'd15, 6'd0,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd15, 4'd5,  4'd15, 6'd0,  SIDE_PX,    1'b1, 6'b000000, 1'b0},
		'{OP_WR_BOUND, 4'd15, 4'd15, 4'd15, 6'd63, SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_WR_VOXEL, 4'd3,  4'd3,  4'd3,  6'd7,  SIDE_PX,    1'b0, 6'b000000, 1'b0},
		'{OP_EXAMINE,  4'd3,  4'd3,  4'd3,  6'd0,  SIDE_PX,    1'b0, 6'b000000, 1'b0}
	};

	voxel_face_culler_unit dut (.*);

	initial forever #10 clk = ~clk;

	function automatic logic [BAW-1:0] border_slot(input logic [SIDE_W-1:0] side,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
		case (side[2:1])
			2'd0: return {side, y, z};
			2'd1: return {side, x, z};
			default: return {side, x, y};
		endcase
	endfunction

	function automatic bit on_edge(input logic [SIDE_W-1:0] side,
		input logic [POS_W-1:0] x, input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
		logic [POS_W-1:0] c;
		case (side[2:1])
			2'd0: c = x;
			2'd1: c = y;
			default: c = z;
		endcase
		return side[0] ? (c == '0) : (c == POS_MAX);
	endfunction

	function automatic bit lets_light(input logic [ID_W-1:0] id);
		return id != '0 && see_through[id - 1'b1];
	endfunction

	function automatic void queue_faces(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
		input logic [POS_W-1:0] z, input logic [ID_W-1:0] id, input logic tr,
		input logic [NUM_SIDES-1:0] visible);
		face_rec_t r;
		for (int s = 0; s < NUM_SIDES; s++) begin
			if (visible[s]) begin
				// chunk edge is 16, so the voxel offset just fills the low four bits
				r.wx   = {origin_x, x};
				r.wy   = {origin_y, y};
				r.wz   = {origin_z, z};
				r.dir  = SIDE_W'(s);
				r.id   = id;
				r.tr   = tr;
				r.last = (visible >> (s + 1)) == '0;
				faces_due.push_back(r);
			end
		end
	endfunction

	function automatic void predict_faces(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
		input logic [POS_W-1:0] z);
		logic [ID_W-1:0]      self_id;
		logic [ID_W-1:0]      nb;
		logic [POS_W-1:0]     q [3];
		logic [NUM_SIDES-1:0] visible;
		bit                   self_tr;
		self_id = chunk_image[{x, y, z}];
		if (self_id == '0)
			return;
		self_tr = lets_light(self_id);
		visible = '0;
		for (int s = 0; s < NUM_SIDES; s++) begin
			if (on_edge(SIDE_W'(s), x, y, z)) begin
				// an absent neighbour chunk always shows the face
				if (!neighbour_on[s]) begin
					visible[s] = 1'b1;
					continue;
				end
				nb = border_image[border_slot(SIDE_W'(s), x, y, z)];
			end else begin
				q[0] = x;
				q[1] = y;
				q[2] = z;
				if (s[0])
					q[s >> 1] = q[s >> 1] - 1'b1;
				else
					q[s >> 1] = q[s >> 1] + 1'b1;
				nb = chunk_image[{q[0], q[1], q[2]}];
			end
			visible[s] = nb == '0 || (!self_tr && lets_light(nb));
		end
		queue_faces(x, y, z, self_id, self_tr, visible);
	endfunction

	function automatic void compare_field(input string what, input logic [WORLD_W-1:0] want,
		input logic [WORLD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	// half the coordinates fall within two of a chunk edge so that edges and neighbours meet often
	function automatic logic [POS_W-1:0] pick_pos();
		logic [POS_W-1:0] v;
		if ($urandom_range(1))
			return POS_W'($urandom);
		v = POS_W'($urandom_range(2));
		return $urandom_range(1) ? POS_MAX - v : v;
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return '0;
		if (r < 35)
			return '1;
		return ID_W'($urandom_range(63, 1));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TMASK:   see_through  = data[TMASK_W-1:0];
			REG_CHUNK_X: origin_x     = data[CPOS_W-1:0];
			REG_CHUNK_Y: origin_y     = data[CPOS_W-1:0];
			REG_CHUNK_Z: origin_z     = data[CPOS_W-1:0];
			REG_PRESENT: neighbour_on = data[NUM_SIDES-1:0];
			default: ;
		endcase
	endtask

	task automatic program_chunk(input int setting);
		logic [CFG_W-1:0] tm;
		logic [CFG_W-1:0] cx;
		logic [CFG_W-1:0] cy;
		logic [CFG_W-1:0] cz;
		logic [CFG_W-1:0] np;
		tm = CFG_W'({$urandom, $urandom});
		cx = CFG_W'({$urandom, $urandom});
		cy = CFG_W'({$urandom, $urandom});
		cz = CFG_W'({$urandom, $urandom});
		np = CFG_W'({$urandom, $urandom});
		case (setting)
			0: begin
				tm = CFG_W'(63'h4000_0000_0000_0002);
				cx = CFG_W'(CPOS_MAX);
				cy = CFG_W'(CPOS_MIN);
				cz = '1;
				np = CFG_W'(6'b101010);
			end
			1: begin
				tm = '1;
				cx = CFG_W'(CPOS_MIN);
				cy = CFG_W'(CPOS_MAX);
				cz = '0;
				np = CFG_W'(6'b111111);
			end
			2: begin
				tm = '0;
				cx = '0;
				cy = CFG_W'({CPOS_W{1'b1}});
				cz = CFG_W'(CPOS_MAX);
				np = '0;
			end
			default: ;
		endcase
		write_reg(REG_TMASK, tm);
		write_reg(REG_CHUNK_X, cx);
		write_reg(REG_CHUNK_Y, cy);
		write_reg(REG_CHUNK_Z, cz);
		write_reg(REG_PRESENT, np);
		// indexes past the register list must change nothing
		for (int i = int'(REG_PRESENT) + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), CFG_W'({$urandom, $urandom}));
	endtask

	task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] x,
		input logic [POS_W-1:0] y, input logic [POS_W-1:0] z, input logic [ID_W-1:0] id,
		input logic [SIDE_W-1:0] side, input logic typed, input logic [NUM_SIDES-1:0] faces,
		input logic tr);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		pos_x     <= x;
		pos_y     <= y;
		pos_z     <= z;
		voxel_id  <= id;
		face_side <= side;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		case (op)
			OP_WR_VOXEL: chunk_image[{x, y, z}] = id;
			OP_WR_BOUND: begin
				if (side <= SIDE_LAST) begin
					border_image[border_slot(side, x, y, z)] = id;
					border_known[border_slot(side, x, y, z)] = 1'b1;
				end
			end
			OP_EXAMINE: begin
				if (typed)
					queue_faces(x, y, z, id, tr, faces);
				else
					predict_faces(x, y, z);
			end
			default: ;
		endcase
	endtask

	task automatic random_item();
		int               pick;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
		pick = $urandom_range(99);
		x = pick_pos();
		y = pick_pos();
		z = pick_pos();
		if (pick < 40) begin
			send_item(OP_WR_VOXEL, x, y, z, pick_id(), SIDE_W'($urandom), 1'b0, '0, 1'b0);
		end else if (pick < 55) begin
			send_item(OP_WR_BOUND, x, y, z, pick_id(), SIDE_W'($urandom_range(SIDE_NZ)),
				1'b0, '0, 1'b0);
		end else if (pick < 95) begin
			// fill any boundary entry this examine would read before it was ever written
			for (int s = 0; s < NUM_SIDES; s++)
				if (neighbour_on[s] && on_edge(SIDE_W'(s), x, y, z)
						&& !border_known[border_slot(SIDE_W'(s), x, y, z)])
					send_item(OP_WR_BOUND, x, y, z, pick_id(), SIDE_W'(s), 1'b0, '0, 1'b0);
			send_item(OP_EXAMINE, x, y, z, ID_W'($urandom), SIDE_W'($urandom), 1'b0, '0, 1'b0);
		end else if (pick < 98) begin
			send_item(OP_SPARE, x, y, z, ID_W'($urandom), SIDE_W'($urandom), 1'b0, '0, 1'b0);
		end else begin
			send_item(OP_WR_BOUND, x, y, z, pick_id(),
				$urandom_range(1) ? SIDE_BAD_A : SIDE_BAD_B, 1'b0, '0, 1'b0);
		end
	endtask

	// drop valid, let every face drain, then give a silent examine time to finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (faces_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		face_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (faces_due.size() == 0) begin
				$display("%0t: face transfer with none expected: expected nothing got dir %0d id %0d",
					$time, face_dir, block_id);
				errors++;
			end else begin
				want = faces_due.pop_front();
				compare_field("world_x", want.wx, world_x);
				compare_field("world_y", want.wy, world_y);
				compare_field("world_z", want.wz, world_z);
				compare_field("face_dir", WORLD_W'(want.dir), WORLD_W'(face_dir));
				compare_field("block_id", WORLD_W'(want.id), WORLD_W'(block_id));
				compare_field("to_transparent", WORLD_W'(want.tr), WORLD_W'(to_transparent));
				compare_field("last_face", WORLD_W'(want.last), WORLD_W'(last_face));
			end
		end
		out_ready <= $urandom_range(99) >= receiver_idle_pct;
	end

	// cycles with no transfer on either side; the post-reset sweep counts here too
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("voxel_face_culler_unit verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < VOXELS; i++)
			chunk_image[i] = '0;
		see_through  = '0;
		origin_x     = '0;
		origin_y     = '0;
		origin_z     = '0;
		neighbour_on = '0;
		sender_idle_pct   = 38;
		receiver_idle_pct = 46;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_chunk(0);
		for (int i = 0; i < PLAN_ROWS; i++)
			send_item(plan[i].op, plan[i].x, plan[i].y, plan[i].z, plan[i].id, plan[i].side,
				plan[i].typed, plan[i].faces, plan[i].tr);
		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			settle();
			program_chunk(p);
			case ((p - 1) / 2)
				0: begin
					sender_idle_pct   = 38;
					receiver_idle_pct = 46;
				end
				1: begin
					sender_idle_pct   = 46;
					receiver_idle_pct = 38;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					settle();
				random_item();
			end
		end
		settle();
		if (errors == 0)
			$display("voxel_face_culler_unit verification clean");
		else
			$display("voxel_face_culler_unit verification failed");
		$finish;
	end

endmodule

// ===== voxel_face_culler_unit.f =====
rtl/core/vfc_pkg.sv
rtl/core/voxel_face_culler_unit.sv
sim/voxel_face_culler_unit_tb.sv
